// ===== hw/rtl/gbfp_pkg.sv =====
// Shared types, constants and field map of the binary frame parser.
package gbfp_pkg;

  // Frame framing bytes and the line feed that ends a text line.
  localparam logic [7:0] SYNC_CHAR1 = 8'hB5;
  localparam logic [7:0] SYNC_CHAR2 = 8'h62;
  localparam logic [7:0] DOLLAR_CHAR = 8'h24;
  localparam logic [7:0] LF_CHAR = 8'h0A;

  // Message classes and ids.
  localparam logic [7:0] CLS_NAV = 8'h01;
  localparam logic [7:0] CLS_ACK = 8'h05;
  localparam logic [7:0] ID_ACK_NAK = 8'h00;
  localparam logic [7:0] ID_ACK_ACK = 8'h01;
  localparam logic [7:0] ID_POSLLH = 8'h02;
  localparam logic [7:0] ID_DOP = 8'h04;
  localparam logic [7:0] ID_SOL = 8'h06;
  localparam logic [7:0] ID_VELNED = 8'h12;

  // Exact payload lengths of the navigation messages.
  localparam logic [15:0] LEN_POSLLH = 16'd28;
  localparam logic [15:0] LEN_DOP = 16'd18;
  localparam logic [15:0] LEN_SOL = 16'd52;
  localparam logic [15:0] LEN_VELNED = 16'd36;

  // Captured field registers.
  localparam int unsigned NUM_FIELDS = 12;
  localparam int unsigned FIELD_IDX_W = 4;
  localparam logic [FIELD_IDX_W-1:0] LAST_FIELD = 4'(NUM_FIELDS - 1);

  // Default length budget of a forwarded text line.
  localparam int unsigned PASSTHRU_LIMIT_DEF = 128;

  // Configuration register indexes.
  typedef enum logic {
    CFG_PASS_EN = 1'b0,
    CFG_LINK_OK = 1'b1
  } cfg_idx_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_FWD      = 2'd0,
    KIND_REPORT   = 2'd1,
    KIND_CSUM_ERR = 2'd2,
    KIND_LEN_ERR  = 2'd3
  } kind_e;

  // What one accepted byte asks of the output side.
  typedef struct packed {
    logic        single;  // one result of kind, fwd and errs
    logic        report;  // run of twelve field reports
    kind_e       kind;
    logic [7:0]  fwd;
    logic [15:0] errs;
  } res_t;

  // Place of a payload byte inside the field registers.
  typedef struct packed {
    logic                   hit;
    logic [FIELD_IDX_W-1:0] field;
    logic [1:0]             bsel;
  } loc_t;

  // Maps a message id and payload offset to a field register byte.
  function automatic loc_t locate(logic [7:0] ident, logic [5:0] off);
    loc_t       loc;
    logic [5:0] rel;
    loc = '0;
    rel = off - 6'd12;
    case (ident)
      ID_SOL: begin
        if (off <= 6'd3) begin
          loc = '{hit: 1'b1, field: 4'd0, bsel: off[1:0]};
        end else if (off == 6'd8 || off == 6'd9) begin
          loc = '{hit: 1'b1, field: 4'd1, bsel: off[1:0]};
        end else if (off == 6'd10) begin
          loc = '{hit: 1'b1, field: 4'd2, bsel: 2'd0};
        end else if (off == 6'd47) begin
          loc = '{hit: 1'b1, field: 4'd3, bsel: 2'd0};
        end
      end
      ID_POSLLH: begin
        if (off >= 6'd4 && off <= 6'd7) begin
          loc = '{hit: 1'b1, field: 4'd4, bsel: off[1:0]};
        end else if (off >= 6'd8 && off <= 6'd11) begin
          loc = '{hit: 1'b1, field: 4'd5, bsel: off[1:0]};
        end else if (off >= 6'd16 && off <= 6'd19) begin
          loc = '{hit: 1'b1, field: 4'd6, bsel: off[1:0]};
        end
      end
      ID_DOP: begin
        if (off == 6'd12 || off == 6'd13) begin
          loc = '{hit: 1'b1, field: 4'd7, bsel: off[1:0]};
        end
      end
      ID_VELNED: begin
        if (off >= 6'd12 && off <= 6'd27) begin
          loc = '{hit: 1'b1, field: 4'd8 + {2'b00, rel[3:2]}, bsel: rel[1:0]};
        end
      end
      default: begin
        loc = '0;
      end
    endcase
    return loc;
  endfunction

endpackage

// ===== hw/rtl/gnss_binary_frame_parser.sv =====
// Top level of the receiver binary frame parser with output staging and report sequencer.
// A result goes to the output register, or, while one still waits there, to the skid stage.
// Throughput: one byte per cycle while the skid stage is empty and no report run is going.
// A good frame with id 0x12 yields twelve field reports from the report sequencer, one per
// cycle while the output register is free, and the input is held off until the last one is staged.
// Reset (asynchronous, active low) returns to sync search and clears all state but the output and skid payload.
module gnss_binary_frame_parser #(
  parameter int unsigned PASSTHRU_LIMIT = gbfp_pkg::PASSTHRU_LIMIT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [3:0]  field_id_o,
  output logic [31:0] field_value_o,
  output logic [7:0]  fwd_byte_o,
  output logic [15:0] error_total_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic        cfg_wdata_i
);
  import gbfp_pkg::*;

  logic pass_en_q, link_ok_q;
  logic in_fire, out_free;
  res_t res;
  logic [31:0] rd_value;
  logic [15:0] err_count;

  logic                   rpt_active_q;
  logic [FIELD_IDX_W-1:0] rpt_idx_q;

  logic        out_valid_q;
  kind_e       out_kind_q;
  logic [3:0]  out_fid_q;
  logic [31:0] out_val_q;
  logic [7:0]  out_fwd_q;
  logic [15:0] out_err_q;
  logic        out_last_q;

  logic        skid_valid_q;
  kind_e       skid_kind_q;
  logic [7:0]  skid_fwd_q;
  logic [15:0] skid_err_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_en_q <= 1'b0;
      link_ok_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PASS_EN: pass_en_q <= cfg_wdata_i;
        CFG_LINK_OK: link_ok_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input side is open unless the skid stage is full or a report run is going.
  assign in_ready_o = !skid_valid_q && !rpt_active_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  gbfp_parser #(
    .PASSTHRU_LIMIT(PASSTHRU_LIMIT)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_fire),
    .rx_byte_i  (rx_byte_i),
    .pass_en_i  (pass_en_q),
    .link_ok_i  (link_ok_q),
    .rd_idx_i   (rpt_idx_q),
    .rd_value_o (rd_value),
    .err_count_o(err_count),
    .res_o      (res)
  );

  // Report sequencer: walks the field registers one per output transfer slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rpt_active_q <= 1'b0;
      rpt_idx_q    <= '0;
    end else if (in_fire && res.report) begin
      rpt_active_q <= 1'b1;
      rpt_idx_q    <= '0;
    end else if (rpt_active_q && !skid_valid_q && out_free) begin
      rpt_idx_q <= rpt_idx_q + FIELD_IDX_W'(1);
      if (rpt_idx_q == LAST_FIELD) begin
        rpt_active_q <= 1'b0;
      end
    end
  end

  // Output register fed from the skid stage, the report sequencer or the parser.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_free) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end
      end else if (rpt_active_q) begin
        if (out_free) begin
          out_valid_q <= 1'b1;
        end
      end else if (in_fire && res.single) begin
        if (out_free) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output and skid payload.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_free) begin
        out_kind_q <= skid_kind_q;
        out_fid_q  <= 4'd0;
        out_val_q  <= 32'd0;
        out_fwd_q  <= skid_fwd_q;
        out_err_q  <= skid_err_q;
        out_last_q <= 1'b1;
      end
    end else if (rpt_active_q) begin
      if (out_free) begin
        out_kind_q <= KIND_REPORT;
        out_fid_q  <= rpt_idx_q;
        out_val_q  <= rd_value;
        out_fwd_q  <= 8'd0;
        out_err_q  <= err_count;
        out_last_q <= (rpt_idx_q == LAST_FIELD);
      end
    end else if (in_fire && res.single) begin
      if (out_free) begin
        out_kind_q <= res.kind;
        out_fid_q  <= 4'd0;
        out_val_q  <= 32'd0;
        out_fwd_q  <= res.fwd;
        out_err_q  <= res.errs;
        out_last_q <= 1'b1;
      end else begin
        skid_kind_q <= res.kind;
        skid_fwd_q  <= res.fwd;
        skid_err_q  <= res.errs;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_kind_q;
  assign field_id_o    = out_fid_q;
  assign field_value_o = out_val_q;
  assign fwd_byte_o    = out_fwd_q;
  assign error_total_o = out_err_q;
  assign last_o        = out_last_q;

  // The skid stage only fills behind a full output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a result while the output register is empty");

  // A report run never starts or continues with a stale skid entry ahead of it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rpt_active_q |-> !skid_valid_q)
    else $error("skid stage busy during a report run");

  // Field reports always carry a field number in range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == KIND_REPORT) |-> (out_fid_q <= LAST_FIELD))
    else $error("field report with an out-of-range field number");

  // Staging the last field ends the report run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rpt_active_q && out_free && rpt_idx_q == LAST_FIELD) |=> !rpt_active_q)
    else $error("report run did not end after the last field");

endmodule

// ===== hw/rtl/gbfp_parser.sv =====
// Byte-wise frame parser: sync search, checksum, field capture and text passthrough.
module gbfp_parser #(
  parameter int unsigned PASSTHRU_LIMIT = gbfp_pkg::PASSTHRU_LIMIT_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 accept_i,
  input  logic [7:0]                           rx_byte_i,
  input  logic                                 pass_en_i,
  input  logic                                 link_ok_i,
  input  logic [gbfp_pkg::FIELD_IDX_W-1:0]     rd_idx_i,
  output logic [31:0]                          rd_value_o,
  output logic [15:0]                          err_count_o,
  output gbfp_pkg::res_t                       res_o
);
  import gbfp_pkg::*;

  // One-hot parse states.
  typedef enum logic [12:0] {
    ST_SYNC1   = 13'b0000000000001,
    ST_SYNC2   = 13'b0000000000010,
    ST_CLASS   = 13'b0000000000100,
    ST_IDENT   = 13'b0000000001000,
    ST_LEN0    = 13'b0000000010000,
    ST_LEN1    = 13'b0000000100000,
    ST_CAPTURE = 13'b0000001000000,
    ST_SKIP    = 13'b0000010000000,
    ST_ACK0    = 13'b0000100000000,
    ST_ACK1    = 13'b0001000000000,
    ST_CS0     = 13'b0010000000000,
    ST_CS1     = 13'b0100000000000,
    ST_PASS    = 13'b1000000000000
  } state_e;

  localparam logic [7:0] BudgetLoad = 8'(PASSTHRU_LIMIT - 1);

  state_e      state_q, state_d;
  logic [7:0]  sum_a_q, sum_a_d, sum_b_q, sum_b_d;
  logic [7:0]  class_q, class_d, ident_q, ident_d;
  logic [15:0] left_q, left_d;
  logic [5:0]  offset_q, offset_d;
  logic [7:0]  first_ck_q, first_ck_d;
  logic [7:0]  budget_q, budget_d;
  logic [15:0] err_q, err_d;
  logic [3:0][7:0] field_q [NUM_FIELDS];

  logic [7:0]  sum_a_add, sum_b_add;
  logic [15:0] full_len, need_len;
  logic [7:0]  budget_dec;
  loc_t        loc;
  logic        cap_we;
  res_t        res;

  // Running Fletcher sums with the current byte folded in.
  assign sum_a_add  = sum_a_q + rx_byte_i;
  assign sum_b_add  = sum_b_q + sum_a_add;
  assign full_len   = {rx_byte_i, left_q[7:0]};
  assign budget_dec = budget_q - 8'd1;
  assign loc        = locate(ident_q, offset_q);

  // Required payload length of a navigation message, zero when not checked.
  always_comb begin
    case (ident_q)
      ID_POSLLH: need_len = LEN_POSLLH;
      ID_DOP:    need_len = LEN_DOP;
      ID_SOL:    need_len = LEN_SOL;
      ID_VELNED: need_len = LEN_VELNED;
      default:   need_len = 16'd0;
    endcase
  end

  // Next-state logic for one received byte.
  always_comb begin
    state_d    = state_q;
    sum_a_d    = sum_a_q;
    sum_b_d    = sum_b_q;
    class_d    = class_q;
    ident_d    = ident_q;
    left_d     = left_q;
    offset_d   = offset_q;
    first_ck_d = first_ck_q;
    budget_d   = budget_q;
    err_d      = err_q;
    cap_we     = 1'b0;
    res        = '0;
    case (state_q)
      ST_SYNC1: begin
        if (rx_byte_i == SYNC_CHAR1) begin
          state_d = ST_SYNC2;
        end else if (rx_byte_i == DOLLAR_CHAR && pass_en_i && link_ok_i) begin
          budget_d   = BudgetLoad;
          state_d    = (BudgetLoad == 8'd0) ? ST_SYNC1 : ST_PASS;
          res.single = 1'b1;
          res.kind   = KIND_FWD;
          res.fwd    = rx_byte_i;
        end
      end
      ST_SYNC2: begin
        if (rx_byte_i == SYNC_CHAR2) begin
          offset_d = 6'd0;
          state_d  = ST_CLASS;
        end else begin
          state_d = ST_SYNC1;
        end
      end
      ST_CLASS: begin
        class_d = rx_byte_i;
        sum_a_d = rx_byte_i;
        sum_b_d = rx_byte_i;
        state_d = ST_IDENT;
      end
      ST_IDENT: begin
        ident_d = rx_byte_i;
        sum_a_d = sum_a_add;
        sum_b_d = sum_b_add;
        state_d = ST_LEN0;
      end
      ST_LEN0: begin
        left_d  = {8'd0, rx_byte_i};
        sum_a_d = sum_a_add;
        sum_b_d = sum_b_add;
        state_d = ST_LEN1;
      end
      ST_LEN1: begin
        left_d  = full_len;
        sum_a_d = sum_a_add;
        sum_b_d = sum_b_add;
        if (class_q == CLS_NAV) begin
          if (need_len == 16'd0) begin
            state_d = ST_SKIP;
          end else if (full_len == need_len) begin
            state_d = ST_CAPTURE;
          end else begin
            // Wrong length on a navigation message.
            err_d      = err_q + 16'd1;
            state_d    = ST_SYNC1;
            res.single = 1'b1;
            res.kind   = KIND_LEN_ERR;
          end
        end else if (class_q == CLS_ACK) begin
          state_d = (ident_q == ID_ACK_NAK || ident_q == ID_ACK_ACK) ? ST_ACK0 : ST_SYNC1;
        end else begin
          state_d = ST_SKIP;
        end
      end
      ST_CAPTURE, ST_SKIP: begin
        if (left_q != 16'd0) begin
          if (state_q == ST_CAPTURE) begin
            cap_we   = loc.hit;
            offset_d = offset_q + 6'd1;
          end
          sum_a_d = sum_a_add;
          sum_b_d = sum_b_add;
          left_d  = left_q - 16'd1;
        end else begin
          first_ck_d = rx_byte_i;
          state_d    = ST_CS1;
        end
      end
      ST_ACK0: begin
        sum_a_d = sum_a_add;
        sum_b_d = sum_b_add;
        state_d = ST_ACK1;
      end
      ST_ACK1: begin
        sum_a_d = sum_a_add;
        sum_b_d = sum_b_add;
        state_d = ST_CS0;
      end
      ST_CS0: begin
        first_ck_d = rx_byte_i;
        state_d    = ST_CS1;
      end
      ST_CS1: begin
        state_d = ST_SYNC1;
        if (first_ck_q == sum_a_q && rx_byte_i == sum_b_q) begin
          res.report = (ident_q == ID_VELNED);
          res.kind   = KIND_REPORT;
        end else begin
          err_d      = err_q + 16'd1;
          res.single = 1'b1;
          res.kind   = KIND_CSUM_ERR;
        end
      end
      ST_PASS: begin
        // Forward until a line feed or the budget runs out.
        budget_d   = budget_dec;
        state_d    = (rx_byte_i == LF_CHAR || budget_dec == 8'd0) ? ST_SYNC1 : ST_PASS;
        res.single = 1'b1;
        res.kind   = KIND_FWD;
        res.fwd    = rx_byte_i;
      end
      default: begin
        state_d = ST_SYNC1;
      end
    endcase
    res.errs = err_d;
  end

  // Parser state registers, updated only on an input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_SYNC1;
      sum_a_q    <= 8'd0;
      sum_b_q    <= 8'd0;
      class_q    <= 8'd0;
      ident_q    <= 8'd0;
      left_q     <= 16'd0;
      offset_q   <= 6'd0;
      first_ck_q <= 8'd0;
      budget_q   <= 8'd0;
      err_q      <= 16'd0;
    end else if (accept_i) begin
      state_q    <= state_d;
      sum_a_q    <= sum_a_d;
      sum_b_q    <= sum_b_d;
      class_q    <= class_d;
      ident_q    <= ident_d;
      left_q     <= left_d;
      offset_q   <= offset_d;
      first_ck_q <= first_ck_d;
      budget_q   <= budget_d;
      err_q      <= err_d;
    end
  end

  // Field registers: one byte lane written per captured payload byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_FIELDS; i++) begin
        field_q[i] <= '0;
      end
    end else if (accept_i && cap_we) begin
      field_q[loc.field][loc.bsel] <= rx_byte_i;
    end
  end

  assign rd_value_o  = field_q[rd_idx_i];
  assign err_count_o = err_q;
  assign res_o       = res;

endmodule
